FILE: hdl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by every module of the block.
`default_nettype none

package pps_pkg;

  localparam int DEF_SLOTS = 16;
  localparam int PCNT_W    = 5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] arrival;
  } in_t;

  typedef struct packed {
    logic [15:0] now;
    logic        run_valid;
    logic [3:0]  run_slot;
    logic        started;
    logic        preempted;
    logic [3:0]  prev_slot;
    logic        completed;
    logic        all_done;
  } res_t;

  // one slot-table entry as held in memory
  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  prio;
    logic [15:0] arrival;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: slot table in memory, sequential scan per item.
// Depends on pps_pkg and pps_slot_ram.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------
//  command  | start, busy, item      | taken when start && !busy
//  result   | done, result           | one-cycle strobe, cannot be stalled
//  config   | cfg_we, cfg_wdata      | process_count written when cfg_we
//
// Every item (load or tick) scans the n slots in use, n = process_count capped
// at SLOTS: one memory read per slot, then the last read data is evaluated,
// the scan closes and S_FIN updates; busy holds off new items until then. The
// result strobe is registered from S_FIN and comes once the block is idle.
// Reset clears time, current slot and marks all slots finished; the memory
// itself needs no clearing pass. The receiver cannot stall.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int SLOTS = pps_pkg::DEF_SLOTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire pps_pkg::in_t              item,
  output logic                           done,
  output pps_pkg::res_t                  result,
  input  wire logic                      cfg_we,
  input  wire logic [pps_pkg::PCNT_W-1:0] cfg_wdata
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t             state;
  logic [PCNT_W-1:0]  process_count;
  logic [SLOTS-1:0]   finished;
  logic [IDX_W-1:0]   current_slot;
  logic               current_valid;
  logic [15:0]        clock_time;

  logic               is_tick;
  logic [CNT_W-1:0]   scan_idx;
  logic               eval_vld;
  logic [IDX_W-1:0]   eval_idx;
  logic [CNT_W-1:0]   unf_cnt;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  entry_t             best;

  logic [CNT_W-1:0]   n_use;
  logic               accept;
  logic               load_ok;
  logic [15:0]        rem_next;
  logic               fin_completed;
  logic               fin_started;
  res_t               result_next;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  entry_t             ram_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_ok = accept && (item.cmd == CMD_LOAD) && (32'(item.slot) < SLOTS);

  always_comb begin
    if (32'(process_count) > SLOTS) begin
      n_use = CNT_W'(SLOTS);
    end else begin
      n_use = CNT_W'(process_count);
    end
  end

  assign rem_next      = (best.rem != 16'd0) ? best.rem - 16'd1 : best.rem;
  assign fin_completed = found && (rem_next == 16'd0);
  assign fin_started   = !current_valid || (current_slot != best_idx);

  always_comb begin
    result_next          = '0;
    result_next.now      = clock_time;
    result_next.all_done = (unf_cnt == '0);
    if (is_tick) begin
      result_next.now      = clock_time + 16'd1;
      result_next.all_done = ((unf_cnt - CNT_W'(fin_completed)) == '0);
      if (found) begin
        result_next.run_valid = 1'b1;
        result_next.run_slot  = 4'(best_idx);
        result_next.started   = fin_started;
        if (fin_started && current_valid) begin
          result_next.preempted = 1'b1;
          result_next.prev_slot = 4'(current_slot);
        end
        result_next.completed = fin_completed;
      end
    end
  end

  // loads write at accept, tick updates write back in the final cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = '{rem: rem_next, prio: best.prio, arrival: best.arrival};
    if (load_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(item.slot);
      ram_wdata = '{rem: item.burst, prio: item.prio, arrival: item.arrival};
    end else if (state == S_FIN && is_tick && found) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state == S_SCAN) && (scan_idx < n_use);

  pps_slot_ram #(
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= '0;
    end else if (cfg_we) begin
      process_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      finished      <= '1;
      current_slot  <= '0;
      current_valid <= 1'b0;
      clock_time    <= '0;
      done          <= 1'b0;
      eval_vld      <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_tick  <= (item.cmd == CMD_TICK);
            scan_idx <= '0;
            eval_vld <= 1'b0;
            unf_cnt  <= '0;
            found    <= 1'b0;
            best_idx <= '0;
            if (load_ok) begin
              finished[IDX_W'(item.slot)] <= (item.burst == 16'd0);
              if (current_valid && current_slot == IDX_W'(item.slot)) begin
                current_valid <= 1'b0;
              end
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (eval_vld && !finished[eval_idx]) begin
            unf_cnt <= unf_cnt + CNT_W'(1);
            if (is_tick && ram_rdata.arrival <= clock_time &&
                (!found || ram_rdata.prio < best.prio)) begin
              found    <= 1'b1;
              best_idx <= eval_idx;
              best     <= ram_rdata;
            end
          end
          if (scan_idx < n_use) begin
            eval_vld <= 1'b1;
            eval_idx <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            eval_vld <= 1'b0;
            if (!eval_vld) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          result <= result_next;
          state  <= S_IDLE;
          if (is_tick) begin
            clock_time <= clock_time + 16'd1;
            if (found) begin
              current_slot  <= best_idx;
              current_valid <= !fin_completed;
              if (fin_completed) begin
                finished[best_idx] <= 1'b1;
              end
            end else begin
              current_valid <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks on result consistency and sequencing
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the block busy");

  a_preempt_implies_start: assert property (@(posedge clk) disable iff (rst)
    (done && result.preempted) |-> (result.started && result.run_valid))
    else $error("preemption reported without a started run");

  a_complete_implies_run: assert property (@(posedge clk) disable iff (rst)
    (done && result.completed) |-> result.run_valid)
    else $error("completion reported with no slot running");

endmodule

`default_nettype wire

FILE: hdl/pps_slot_ram.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on pps_pkg for the entry type.
`default_nettype none

module pps_slot_ram #(
  parameter  int DEPTH = pps_pkg::DEF_SLOTS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire pps_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output pps_pkg::entry_t      rdata
);
  import pps_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: verif/pps_schedule_checker.sv
// Scoreboard for the preemptive priority scheduler: predicts each result from accepted items
// and register writes, then compares the strobed results in order.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_schedule_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire pps_pkg::in_t  item,
  input  wire logic          done,
  input  wire pps_pkg::res_t result,
  input  wire logic          cfg_we,
  input  wire logic [4:0]    cfg_wdata,
  output int                 failures,
  output int                 pending
);
  import pps_pkg::*;

  localparam int SLOTS = DEF_SLOTS;

  // shadow copy of the slot table and scheduler state
  logic [15:0] rem_left  [SLOTS];
  logic [7:0]  prio_of   [SLOTS];
  logic [15:0] arrive_at [SLOTS];
  logic        fin       [SLOTS];
  logic [3:0]  cur_slot;
  logic        cur_valid;
  logic [15:0] clock_now;
  logic [4:0]  proc_count;

  res_t expected_q[$];

  function automatic res_t schedule_step(input in_t it);
    res_t r;
    int n, i, pick;
    bit found;
    r = '0;
    n = (proc_count > SLOTS) ? SLOTS : proc_count;
    if (it.cmd == CMD_LOAD) begin
      rem_left[it.slot]  = it.burst;
      prio_of[it.slot]   = it.prio;
      arrive_at[it.slot] = it.arrival;
      fin[it.slot]       = (it.burst == 16'd0);
      // reloading the running slot drops it silently
      if (cur_valid && cur_slot == it.slot) cur_valid = 1'b0;
    end else begin
      found = 1'b0;
      pick  = 0;
      for (i = 0; i < n; i++) begin
        if (!fin[i] && arrive_at[i] <= clock_now && (!found || prio_of[i] < prio_of[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.run_valid = 1'b1;
        r.run_slot  = pick[3:0];
        if (!cur_valid || cur_slot != pick[3:0]) begin
          r.started = 1'b1;
          if (cur_valid) begin
            r.preempted = 1'b1;
            r.prev_slot = cur_slot;
          end
        end
        cur_slot  = pick[3:0];
        cur_valid = 1'b1;
        if (rem_left[pick] != 16'd0) rem_left[pick] = rem_left[pick] - 16'd1;
        if (rem_left[pick] == 16'd0) begin
          fin[pick]   = 1'b1;
          r.completed = 1'b1;
          cur_valid   = 1'b0;
        end
      end else begin
        cur_valid = 1'b0;
      end
      clock_now = clock_now + 16'd1;
    end
    r.now      = clock_now;
    r.all_done = 1'b1;
    for (i = 0; i < n; i++)
      if (!fin[i]) r.all_done = 1'b0;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        rem_left[i]  = '0;
        prio_of[i]   = '0;
        arrive_at[i] = '0;
        fin[i]       = 1'b1;
      end
      cur_slot   = '0;
      cur_valid  = 1'b0;
      clock_now  = '0;
      proc_count = '0;
      failures   = 0;
      expected_q.delete();
    end else begin
      // a strobe always belongs to an item taken at an earlier edge
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          failures++;
        end else begin
          want = expected_q.pop_front();
          check_field("now",       int'(want.now),       int'(result.now));
          check_field("run_valid", int'(want.run_valid), int'(result.run_valid));
          check_field("run_slot",  int'(want.run_slot),  int'(result.run_slot));
          check_field("started",   int'(want.started),   int'(result.started));
          check_field("preempted", int'(want.preempted), int'(result.preempted));
          check_field("prev_slot", int'(want.prev_slot), int'(result.prev_slot));
          check_field("completed", int'(want.completed), int'(result.completed));
          check_field("all_done",  int'(want.all_done),  int'(result.all_done));
        end
      end
      if (start && !busy) expected_q.push_back(schedule_step(item));
      if (cfg_we) proc_count = cfg_wdata;
    end
    pending = expected_q.size();
  end

endmodule

FILE: verif/preemptive_priority_scheduler_test.sv
// Top of the scheduler testbench: clock, reset, directed and random command items,
// process_count settings and the verdict. Depends on pps_pkg, the block and pps_schedule_checker.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 850;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  in_t        item = '0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       busy;
  logic       done;
  res_t       result;

  int          failures;
  int          pending;
  int          items_sent = 0;
  logic [15:0] ticks_sent = '0;   // mirrors the block's time
  bit          gaps_on = 1'b1;
  int          idle_cycles = 0;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pps_schedule_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // nothing taken and nothing returned for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_cmd(input in_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    if (it.cmd == CMD_TICK) ticks_sent++;
  endtask

  task automatic load_slot(input logic [3:0] s, input logic [15:0] b, input logic [7:0] p,
                           input logic [15:0] a);
    in_t it;
    it.cmd     = CMD_LOAD;
    it.slot    = s;
    it.burst   = b;
    it.prio    = p;
    it.arrival = a;
    send_cmd(it);
  endtask

  // fields other than cmd are don't-care on a tick, so they get noise
  task automatic tick();
    in_t it;
    it         = '0;
    it.cmd     = CMD_TICK;
    it.slot    = 4'($urandom);
    it.burst   = 16'($urandom);
    it.prio    = 8'($urandom);
    it.arrival = 16'($urandom);
    send_cmd(it);
  endtask

  // wait until every result is back and the block is free
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          pc, n, sel, span, s, k, phase_end;
    logic [15:0] at;
    logic [15:0] b;
    logic [7:0]  p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no slots in use: idle tick, then write every slot so none is left undefined
    tick();
    load_slot(4'd0, 16'd3, 8'd5, 16'd0);
    load_slot(4'd1, 16'd2, 8'd2, 16'd2);
    load_slot(4'd2, 16'd0, 8'd0, 16'd0);              // zero burst, finished at once
    load_slot(4'd3, 16'hFFFF, 8'hFF, 16'hFFFF);       // arrives only at the last tick before wrap
    for (s = 4; s < 16; s++)
      load_slot(s[3:0], 16'd0, s[0] ? 8'hFF : 8'h00, s[0] ? 16'hFFFF : 16'h0000);
    settle();
    write_count(5'd4);
    tick();                                           // slot 0 starts
    tick();                                           // slot 1 arrives and preempts
    tick();                                           // slot 1 completes
    tick();                                           // slot 0 resumes
    load_slot(4'd0, 16'd2, 8'd5, 16'd0);              // reload of the running slot
    tick();
    tick();
    tick();                                           // nothing eligible
    load_slot(4'd1, 16'd1, 8'd7, 16'd0);
    load_slot(4'd2, 16'd1, 8'd7, 16'd0);
    tick();                                           // equal priorities, lower slot wins
    tick();

    phase_end = items_sent + RANDOM_ITEMS;
    while (items_sent < phase_end) begin
      settle();
      sel = $urandom_range(0, 9);
      if (sel == 0)      pc = 0;
      else if (sel == 1) pc = 16;
      else if (sel == 2) pc = $urandom_range(17, 31);
      else               pc = $urandom_range(1, 6);
      write_count(pc[4:0]);
      gaps_on = ($urandom_range(0, 3) != 0);
      n  = (pc > 16) ? 16 : pc;
      at = ticks_sent;
      // mostly well-formed set: every slot in use is loaded, most in arrival order
      for (s = 0; s < n; s++) begin
        if ($urandom_range(0, 7) == 0) begin
          load_slot(s[3:0], 16'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          at = at + 16'($urandom_range(0, 4));
          p  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          load_slot(s[3:0], 16'($urandom_range(0, 6)), p, at);
        end
      end
      span = 4 * n + $urandom_range(2, 10);
      for (k = 0; k < span; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          // late arrival or reload of a random slot, which may be the running one
          b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
          p = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          load_slot(4'($urandom_range(0, 15)), b, p,
                    ticks_sent + 16'($urandom_range(0, 3)));
        end
        tick();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: preemptive_priority_scheduler.f
hdl/pps_pkg.sv
hdl/pps_slot_ram.sv
hdl/preemptive_priority_scheduler.sv
verif/pps_schedule_checker.sv
verif/preemptive_priority_scheduler_test.sv
